FILE: rtl/rwpu_pkg.sv
// ----------------------------------------------------------------------------
// rwpu_pkg
// Shared types, widths and codes for the reward-weighted policy update block.
// ----------------------------------------------------------------------------
package rwpu_pkg;

   // Storage sizes
   localparam int MAX_WEIGHTS = 64;
   localparam int MAX_BEST    = 8;

   // Field and index widths
   localparam int DATA_W  = 32;
   localparam int WIDX_W  = 6;               // weight index
   localparam int LEN_W   = 7;               // vector_length register
   localparam int CNT_W   = 4;               // best_count register, rank counts
   localparam int RANK_W  = 3;               // rank index
   localparam int BEST_AW = RANK_W + WIDX_W; // best weight set address
   localparam int CSR_AW  = 1;
   localparam int CSR_DW  = 7;

   // Update arithmetic widths
   localparam int DIFF_W = DATA_W + 1;       // best minus policy weight
   localparam int PROD_W = DATA_W + DIFF_W;  // reward times difference
   localparam int NUM_W  = PROD_W + 3;       // sum over up to eight ranks
   localparam int MAG_W  = NUM_W - 1;        // magnitude of the sum
   localparam int DEN_W  = DATA_W + 3;       // signed reward sum
   localparam int DIV_W  = DEN_W - 1;        // positive reward sum
   localparam int Q_W    = 41;               // step, saturated to 2^40
   localparam int STEP_W = 7;                // divider step counter
   localparam int NW_W   = Q_W + 2;          // new weight before clamp

   localparam logic [DATA_W-1:0] MIN_REWARD = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic [DATA_W-1:0] MAX_WORD   = {1'b0, {(DATA_W-1){1'b1}}};

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_TRIAL  = 2'd1,
      OP_REWARD = 2'd2,
      OP_READ   = 2'd3
   } opcode_type;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_UPDATE = 2'd1;
   localparam logic [1:0] STATUS_RANGE     = 2'd2;

   localparam logic [CSR_AW-1:0] CSR_BEST_COUNT    = 1'd0;
   localparam logic [CSR_AW-1:0] CSR_VECTOR_LENGTH = 1'd1;

   // Outcome of a reward insertion
   typedef struct packed {
      logic              hit;
      logic [RANK_W-1:0] rank;
   } rank_result_type;

endpackage

FILE: rtl/rwpu_req_if.sv
// ----------------------------------------------------------------------------
// rwpu_req_if
// Request channel: one command per transfer.
// ----------------------------------------------------------------------------
interface rwpu_req_if;
   import rwpu_pkg::*;

   logic              valid;
   logic              ready;
   logic [1:0]        opcode;
   logic [WIDX_W-1:0] index;
   logic [DATA_W-1:0] value;

   modport source (output valid, output opcode, output index, output value, input ready);
   modport sink   (input valid, input opcode, input index, input value, output ready);
endinterface

FILE: rtl/rwpu_rsp_if.sv
// ----------------------------------------------------------------------------
// rwpu_rsp_if
// Response channel: one result per command.
// ----------------------------------------------------------------------------
interface rwpu_rsp_if;
   import rwpu_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_value;
   logic              inserted;
   logic [RANK_W-1:0] rank;
   logic [1:0]        status;

   modport source (output valid, output read_value, output inserted, output rank,
                   output status, input ready);
   modport sink   (input valid, input read_value, input inserted, input rank,
                   input status, output ready);
endinterface

FILE: rtl/rwpu_divider.sv
// ----------------------------------------------------------------------------
// rwpu_divider
// Restoring divider, one quotient bit per cycle; result saturated to 2^40.
// ----------------------------------------------------------------------------
module rwpu_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [rwpu_pkg::MAG_W-1:0]   dividend,
   input  logic [rwpu_pkg::DIV_W-1:0]   divisor,
   output logic                         done,
   output logic [rwpu_pkg::Q_W-1:0]     quotient
);
   import rwpu_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [MAG_W-1:0]  dvd_ff, dvd_in;
   logic [DIV_W-1:0]  dsr_ff, dsr_in;

   logic [DIV_W:0]    shifted;
   logic [DIV_W:0]    diff;
   logic              fits;
   logic              sat;

   // One restoring step
   always_comb begin
      shifted = {rem_ff, dvd_ff[MAG_W-1]};
      diff    = shifted - {1'b0, dsr_ff};
      fits    = shifted >= {1'b0, dsr_ff};
   end

   // Sequence the steps
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
         dvd_in  = {dvd_ff[MAG_W-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(MAG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   // Clamp the quotient to 2^40
   always_comb begin
      sat      = (|dvd_ff[MAG_W-1:Q_W]) || (dvd_ff[Q_W-1] && (|dvd_ff[Q_W-2:0]));
      quotient = sat ? {1'b1, {(Q_W-1){1'b0}}} : dvd_ff[Q_W-1:0];
   end

   assign done = done_ff;
endmodule

FILE: rtl/rwpu_rank.sv
// ----------------------------------------------------------------------------
// rwpu_rank
// Ranked reward list, one reward per row of the best weight set memory,
// plus the closed trial count.
// ----------------------------------------------------------------------------
module rwpu_rank (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              insert_en,
   input  logic [rwpu_pkg::DATA_W-1:0]       insert_value,
   input  logic [rwpu_pkg::CNT_W-1:0]        k,
   output rwpu_pkg::rank_result_type         result,
   input  logic [rwpu_pkg::RANK_W-1:0]       rd_rank,
   output logic [rwpu_pkg::DATA_W-1:0]       rd_reward,
   output logic [rwpu_pkg::CNT_W-1:0]        trials_done
);
   import rwpu_pkg::*;

   logic [DATA_W-1:0] reward_ff [MAX_BEST];
   logic [CNT_W-1:0]  trials_ff;

   // Find the first rank that the new reward beats
   always_comb begin
      result = '0;
      for (int i = 0; i < MAX_BEST; i++) begin
         if (!result.hit && (CNT_W'(i) < k) &&
             ($signed(insert_value) > $signed(reward_ff[i]))) begin
            result.hit  = 1'b1;
            result.rank = RANK_W'(i);
         end
      end
   end

   // Shift lower ranks down, the last one drops out
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_BEST; i++) begin
            reward_ff[i] <= MIN_REWARD;
         end
         trials_ff <= '0;
      end else if (insert_en) begin
         if (result.hit) begin
            for (int r = 1; r < MAX_BEST; r++) begin
               if ((RANK_W'(r) > result.rank) && (CNT_W'(r) < k)) begin
                  reward_ff[r] <= reward_ff[r-1];
               end
            end
            reward_ff[result.rank] <= insert_value;
         end
         if (trials_ff != '1) begin
            trials_ff <= trials_ff + 1'b1;
         end
      end
   end

   assign rd_reward   = reward_ff[rd_rank];
   assign trials_done = trials_ff;
endmodule

FILE: rtl/reward_weighted_policy_update.sv
// ----------------------------------------------------------------------------
// reward_weighted_policy_update
// Policy weights with a ranked list of best trials; a closing reward inserts
// the trial if it ranks and moves weights when the reward sum is positive.
// ----------------------------------------------------------------------------
// A reward rewrites the rows of the best weight set memory for the ranks
// shifted down plus the inserted one, none when the reward is not inserted;
// each rewritten row is one pass of L reads and writes, with L the weights
// in use. It then sums the rewards of the U ranks averaged and, only when
// that sum is positive, moves each weight by the reward-weighted mean
// difference. Per weight, each rank costs a read, a multiply and an
// accumulate on the best weight set memory, and the step comes from a
// one-bit-per-cycle divider. A stalled result channel adds its stall.
// Configuration must be written only while the block is idle; the block
// itself does not enforce this.
module reward_weighted_policy_update (
   input  logic                           clock,
   input  logic                           reset,
   rwpu_req_if.sink                       req_chan,
   rwpu_rsp_if.source                     rsp_chan,
   input  logic                           csr_write_en,
   input  logic [rwpu_pkg::CSR_AW-1:0]    csr_index,
   input  logic [rwpu_pkg::CSR_DW-1:0]    csr_data
);
   import rwpu_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE  = 12'b000000000001,
      S_RESP  = 12'b000000000010,
      S_COPY  = 12'b000000000100,
      S_DEN   = 12'b000000001000,
      S_RD_W  = 12'b000000010000,
      S_RD_B  = 12'b000000100000,
      S_MUL   = 12'b000001000000,
      S_ACC   = 12'b000010000000,
      S_SIGN  = 12'b000100000000,
      S_DIV   = 12'b001000000000,
      S_WB    = 12'b010000000000,
      S_SHIFT = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers
   logic [CNT_W-1:0] best_count_ff;
   logic [LEN_W-1:0] vector_length_ff;
   logic [CNT_W-1:0] k_eff;
   logic [LEN_W-1:0] l_eff;

   // Memories
   logic [DATA_W-1:0] pol_mem_ff   [MAX_WEIGHTS];
   logic [DATA_W-1:0] trial_mem_ff [MAX_WEIGHTS];
   logic [DATA_W-1:0] best_mem_ff  [MAX_WEIGHTS * MAX_BEST];
   logic [DATA_W-1:0] pol_rdata_ff, trial_rdata_ff, best_rdata_ff;

   logic               pol_we, pol_re, trial_we, trial_re, best_we, best_re;
   logic [WIDX_W-1:0]  pol_waddr, pol_raddr, trial_waddr, trial_raddr;
   logic [DATA_W-1:0]  pol_wdata, trial_wdata, best_wdata;
   logic [BEST_AW-1:0] best_waddr, best_raddr;

   // Work registers
   logic                     accept;
   opcode_type               req_op;
   logic                     in_range;
   logic [LEN_W-1:0]         cnt_ff, cnt_in, cnt_m1;
   logic [CNT_W-1:0]         ri_ff, ri_in, used_ff, used_in;
   logic [RANK_W-1:0]        fill_rank_ff, fill_rank_in;
   logic [RANK_W-1:0]        row_ff, row_in, row_m1;
   logic [RANK_W-1:0]        last_row;
   logic signed [DEN_W-1:0]  den_ff, den_in;
   logic signed [NUM_W-1:0]  num_ff, num_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [DIFF_W-1:0] diff;
   logic                     neg_ff, neg_in;
   logic [NUM_W-1:0]         num_abs;
   logic signed [NW_W-1:0]   new_w;
   logic [DATA_W-1:0]        new_w_sat;

   // Result registers
   logic              res_read_ff, res_read_in;
   logic              res_ins_ff, res_ins_in;
   logic [RANK_W-1:0] res_rank_ff, res_rank_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_read_ff, rsp_read_in;
   logic              rsp_ins_ff, rsp_ins_in;
   logic [RANK_W-1:0] rsp_rank_ff, rsp_rank_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;

   // Rank list and divider hookup
   rank_result_type   rank_result;
   logic              rank_insert;
   logic [DATA_W-1:0] rank_reward;
   logic [CNT_W-1:0]  trials_done;
   logic              div_start, div_done;
   logic [Q_W-1:0]    div_q;

   rwpu_rank u_rank (
      .clock        (clock),
      .reset        (reset),
      .insert_en    (rank_insert),
      .insert_value (req_chan.value),
      .k            (k_eff),
      .result       (rank_result),
      .rd_rank      (ri_ff[RANK_W-1:0]),
      .rd_reward    (rank_reward),
      .trials_done  (trials_done)
   );

   rwpu_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_abs[MAG_W-1:0]),
      .divisor  (den_ff[DIV_W-1:0]),
      .done     (div_done),
      .quotient (div_q)
   );

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         best_count_ff    <= CNT_W'(1);
         vector_length_ff <= LEN_W'(MAX_WEIGHTS);
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_BEST_COUNT:    best_count_ff    <= csr_data[CNT_W-1:0];
            CSR_VECTOR_LENGTH: vector_length_ff <= csr_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the registers to their usable range
   always_comb begin
      if (best_count_ff == '0) k_eff = CNT_W'(1);
      else if (best_count_ff > CNT_W'(MAX_BEST)) k_eff = CNT_W'(MAX_BEST);
      else k_eff = best_count_ff;
      if (vector_length_ff == '0) l_eff = LEN_W'(1);
      else if (vector_length_ff > LEN_W'(MAX_WEIGHTS)) l_eff = LEN_W'(MAX_WEIGHTS);
      else l_eff = vector_length_ff;
   end

   assign accept   = req_chan.valid && req_chan.ready;
   assign req_op   = opcode_type'(req_chan.opcode);
   assign in_range = {1'b0, req_chan.index} < l_eff;
   assign cnt_m1   = cnt_ff - 1'b1;
   assign row_m1   = row_ff - 1'b1;
   assign last_row = RANK_W'(k_eff - 1'b1);
   assign req_chan.ready = (state_ff == S_IDLE);
   assign rank_insert    = accept && (req_op == OP_REWARD);
   assign div_start      = (state_ff == S_SIGN);

   // Datapath arithmetic
   always_comb begin
      diff    = $signed({best_rdata_ff[DATA_W-1], best_rdata_ff})
              - $signed({pol_rdata_ff[DATA_W-1], pol_rdata_ff});
      prod_in = $signed(rank_reward) * diff;
      num_abs = num_ff[NUM_W-1] ? (~num_ff + 1'b1) : num_ff;
      if (neg_ff) begin
         new_w = $signed({{(NW_W-DATA_W){pol_rdata_ff[DATA_W-1]}}, pol_rdata_ff})
               - $signed({2'b00, div_q});
      end else begin
         new_w = $signed({{(NW_W-DATA_W){pol_rdata_ff[DATA_W-1]}}, pol_rdata_ff})
               + $signed({2'b00, div_q});
      end
      if (!new_w[NW_W-1] && (|new_w[NW_W-2:DATA_W-1])) new_w_sat = MAX_WORD;
      else if (new_w[NW_W-1] && !(&new_w[NW_W-2:DATA_W-1])) new_w_sat = MIN_REWARD;
      else new_w_sat = new_w[DATA_W-1:0];
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      ri_in         = ri_ff;
      used_in       = used_ff;
      fill_rank_in  = fill_rank_ff;
      row_in        = row_ff;
      den_in        = den_ff;
      num_in        = num_ff;
      neg_in        = neg_ff;
      res_read_in   = res_read_ff;
      res_ins_in    = res_ins_ff;
      res_rank_in   = res_rank_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_read_in   = rsp_read_ff;
      rsp_ins_in    = rsp_ins_ff;
      rsp_rank_in   = rsp_rank_ff;
      rsp_status_in = rsp_status_ff;
      pol_we = 1'b0; pol_re = 1'b0; trial_we = 1'b0; trial_re = 1'b0;
      best_we = 1'b0; best_re = 1'b0;
      pol_waddr   = req_chan.index;
      pol_wdata   = req_chan.value;
      pol_raddr   = req_chan.index;
      trial_waddr = req_chan.index;
      trial_wdata = req_chan.value;
      trial_raddr = cnt_ff[WIDX_W-1:0];
      best_waddr  = {fill_rank_ff, cnt_m1[WIDX_W-1:0]};
      best_wdata  = trial_rdata_ff;
      best_raddr  = {ri_ff[RANK_W-1:0], cnt_ff[WIDX_W-1:0]};

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_read_in   = 1'b0;
               res_ins_in    = 1'b0;
               res_rank_in   = '0;
               res_status_in = STATUS_OK;
               cnt_in        = '0;
               ri_in         = '0;
               den_in        = '0;
               state_in      = S_RESP;
               if (req_op == OP_REWARD) begin
                  res_ins_in   = rank_result.hit;
                  res_rank_in  = rank_result.hit ? rank_result.rank : '0;
                  fill_rank_in = rank_result.rank;
                  row_in       = last_row;
                  used_in      = (trials_done >= k_eff) ? k_eff : trials_done + 1'b1;
                  if (!rank_result.hit) state_in = S_DEN;
                  else if (last_row > rank_result.rank) state_in = S_SHIFT;
                  else state_in = S_COPY;
               end else if (!in_range) begin
                  res_status_in = STATUS_RANGE;
               end else begin
                  case (req_op)
                     OP_LOAD:  pol_we   = 1'b1;
                     OP_TRIAL: trial_we = 1'b1;
                     OP_READ: begin
                        pol_re      = 1'b1;
                        res_read_in = 1'b1;
                     end
                     default: ;
                  endcase
               end
            end
         end

         // Move one row of weights down a rank, each word read in the cycle before its write
         S_SHIFT: begin
            best_re    = cnt_ff < l_eff;
            best_raddr = {row_m1, cnt_ff[WIDX_W-1:0]};
            best_we    = cnt_ff != '0;
            best_waddr = {row_ff, cnt_m1[WIDX_W-1:0]};
            best_wdata = best_rdata_ff;
            if (cnt_ff == l_eff) begin
               cnt_in = '0;
               row_in = row_m1;
               if (row_m1 == fill_rank_ff) state_in = S_COPY;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         // Copy the trial into the inserted rank, each word read in the cycle before its write
         S_COPY: begin
            trial_re = cnt_ff < l_eff;
            best_we  = cnt_ff != '0;
            if (cnt_ff == l_eff) begin
               cnt_in   = '0;
               state_in = S_DEN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         // Sum the rewards of the ranks in use
         S_DEN: begin
            if (ri_ff == used_ff) begin
               if (den_ff[DEN_W-1] || (den_ff == '0)) begin
                  res_status_in = STATUS_NO_UPDATE;
                  state_in      = S_RESP;
               end else begin
                  state_in = S_RD_W;
               end
            end else begin
               den_in = den_ff + DEN_W'($signed(rank_reward));
               ri_in  = ri_ff + 1'b1;
            end
         end

         S_RD_W: begin
            pol_re    = 1'b1;
            pol_raddr = cnt_ff[WIDX_W-1:0];
            ri_in     = '0;
            num_in    = '0;
            state_in  = S_RD_B;
         end

         S_RD_B: begin
            best_re  = 1'b1;
            state_in = S_MUL;
         end

         S_MUL: begin
            state_in = S_ACC;
         end

         S_ACC: begin
            num_in = num_ff + NUM_W'(prod_ff);
            ri_in  = ri_ff + 1'b1;
            if (ri_ff + 1'b1 == used_ff) state_in = S_SIGN;
            else state_in = S_RD_B;
         end

         S_SIGN: begin
            neg_in   = num_ff[NUM_W-1];
            state_in = S_DIV;
         end

         S_DIV: begin
            if (div_done) state_in = S_WB;
         end

         // Write the moved weight back and advance
         S_WB: begin
            pol_we    = 1'b1;
            pol_waddr = cnt_ff[WIDX_W-1:0];
            pol_wdata = new_w_sat;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff + 1'b1 == l_eff) state_in = S_RESP;
            else state_in = S_RD_W;
         end

         // Hold the result until the output register frees up
         S_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_read_in   = res_read_ff ? pol_rdata_ff : '0;
               rsp_ins_in    = res_ins_ff;
               rsp_rank_in   = res_rank_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Control and work registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff        <= cnt_in;
      ri_ff         <= ri_in;
      used_ff       <= used_in;
      fill_rank_ff  <= fill_rank_in;
      row_ff        <= row_in;
      den_ff        <= den_in;
      num_ff        <= num_in;
      prod_ff       <= prod_in;
      neg_ff        <= neg_in;
      res_read_ff   <= res_read_in;
      res_ins_ff    <= res_ins_in;
      res_rank_ff   <= res_rank_in;
      res_status_ff <= res_status_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_ins_ff    <= rsp_ins_in;
      rsp_rank_ff   <= rsp_rank_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Policy weight memory
   always_ff @(posedge clock) begin
      if (pol_we) pol_mem_ff[pol_waddr] <= pol_wdata;
      if (pol_re) pol_rdata_ff <= pol_mem_ff[pol_raddr];
   end

   // Trial weight memory
   always_ff @(posedge clock) begin
      if (trial_we) trial_mem_ff[trial_waddr] <= trial_wdata;
      if (trial_re) trial_rdata_ff <= trial_mem_ff[trial_raddr];
   end

   // Best weight set memory, one row of weights per rank
   always_ff @(posedge clock) begin
      if (best_we) best_mem_ff[best_waddr] <= best_wdata;
      if (best_re) best_rdata_ff <= best_mem_ff[best_raddr];
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.read_value = rsp_read_ff;
   assign rsp_chan.inserted   = rsp_ins_ff;
   assign rsp_chan.rank       = rsp_rank_ff;
   assign rsp_chan.status     = rsp_status_ff;
endmodule

FILE: bench/rwpu_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rwpu_checker
// Watches the command, response and register ports of the policy update
// block, keeps its own copy of weights, best trials and registers, works out
// the response of every accepted command and compares it with what comes out.
// ----------------------------------------------------------------------------
module rwpu_checker (
   input  logic                        clock,
   input  logic                        reset,
   rwpu_req_if                         req_mon,
   rwpu_rsp_if                         rsp_mon,
   input  logic                        csr_write_en,
   input  logic [rwpu_pkg::CSR_AW-1:0] csr_index,
   input  logic [rwpu_pkg::CSR_DW-1:0] csr_data,
   output int                          pending,
   output int                          fail_count
);
   import rwpu_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0] read_value;
      logic              inserted;
      logic [RANK_W-1:0] rank;
      logic [1:0]        status;
   } rsp_fields_type;

   rsp_fields_type expected_rsp_q[$];

   // Shadow state of the block
   logic [CNT_W-1:0]        best_cnt_reg;
   logic [LEN_W-1:0]        vec_len_reg;
   logic signed [DATA_W-1:0] policy_w  [MAX_WEIGHTS];
   logic signed [DATA_W-1:0] trial_w   [MAX_WEIGHTS];
   logic signed [DATA_W-1:0] best_rew  [MAX_BEST];
   logic signed [DATA_W-1:0] best_set  [MAX_BEST][MAX_WEIGHTS];
   int                       trial_cnt;

   // Move every weight by the reward-weighted mean of best minus current
   task automatic move_weights(input int k, input int l, input int used,
                               output logic [1:0] status);
      logic signed [127:0] den_sum, num, rew, diff, wide_w, step_s, nw;
      logic [127:0]        mag, quot, den_u;
      logic                neg;
      den_sum = 0;
      status  = STATUS_OK;
      for (int i = 0; i < used && i < k; i++) den_sum = den_sum + best_rew[i];
      if (den_sum <= 0) begin
         status = STATUS_NO_UPDATE;
         return;
      end
      den_u = den_sum;
      for (int j = 0; j < l; j++) begin
         wide_w = policy_w[j];
         num = 0;
         for (int i = 0; i < used && i < k; i++) begin
            rew  = best_rew[i];
            diff = best_set[i][j];
            diff = diff - wide_w;
            num  = num + rew * diff;
         end
         neg  = num < 0;
         mag  = neg ? -num : num;
         quot = mag / den_u;
         if (quot > (128'd1 << 40)) quot = 128'd1 << 40;
         step_s = quot;
         nw = neg ? wide_w - step_s : wide_w + step_s;
         if (nw > 128'sd2147483647) nw = 128'sd2147483647;
         else if (nw < -128'sd2147483648) nw = -128'sd2147483648;
         policy_w[j] = nw[DATA_W-1:0];
      end
   endtask

   // Apply one command to the shadow state and return its response
   task automatic run_command(input opcode_type op, input logic [WIDX_W-1:0] idx,
                              input logic signed [DATA_W-1:0] val,
                              output rsp_fields_type res);
      int k, l, used;
      k = (best_cnt_reg < 1) ? 1 : (best_cnt_reg > MAX_BEST) ? MAX_BEST : best_cnt_reg;
      l = (vec_len_reg < 1) ? 1 : (vec_len_reg > MAX_WEIGHTS) ? MAX_WEIGHTS : vec_len_reg;
      res = '0;
      if (op == OP_REWARD) begin
         // insert at the first rank that the reward strictly beats
         for (int i = 0; i < k; i++) begin
            if (!res.inserted && val > best_rew[i]) begin
               for (int r = k - 1; r > i; r--) begin
                  best_rew[r] = best_rew[r-1];
                  for (int j = 0; j < l; j++) best_set[r][j] = best_set[r-1][j];
               end
               best_rew[i] = val;
               for (int j = 0; j < l; j++) best_set[i][j] = trial_w[j];
               res.inserted = 1'b1;
               res.rank     = RANK_W'(i);
            end
         end
         used = (trial_cnt + 1 > k) ? k : trial_cnt + 1;
         move_weights(k, l, used, res.status);
         if (trial_cnt < 15) trial_cnt++;
      end else if (idx >= l) begin
         res.status = STATUS_RANGE;
      end else if (op == OP_LOAD) begin
         policy_w[idx] = val;
      end else if (op == OP_TRIAL) begin
         trial_w[idx] = val;
      end else begin
         res.read_value = policy_w[idx];
      end
   endtask

   // Predict on command transfers, compare on response transfers
   always @(posedge clock) begin
      rsp_fields_type res, exp_res;
      if (reset) begin
         best_cnt_reg = 4'd1;
         vec_len_reg  = 7'd64;
         trial_cnt    = 0;
         for (int i = 0; i < MAX_BEST; i++) best_rew[i] = MIN_REWARD;
         expected_rsp_q.delete();
         fail_count = 0;
      end else begin
         if (csr_write_en) begin
            if (csr_index == CSR_BEST_COUNT) best_cnt_reg = csr_data[CNT_W-1:0];
            else if (csr_index == CSR_VECTOR_LENGTH) vec_len_reg = csr_data[LEN_W-1:0];
         end
         if (req_mon.valid && req_mon.ready) begin
            run_command(opcode_type'(req_mon.opcode), req_mon.index, req_mon.value, res);
            expected_rsp_q.push_back(res);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            res = {rsp_mon.read_value, rsp_mon.inserted, rsp_mon.rank, rsp_mon.status};
            if (expected_rsp_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: response with nothing outstanding: value %h ins %b rank %0d status %0d",
                           $realtime, res.read_value, res.inserted, res.rank, res.status);
            end else begin
               exp_res = expected_rsp_q.pop_front();
               if (res !== exp_res) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: mismatch: value %h/%h ins %b/%b rank %0d/%0d status %0d/%0d (exp/got)",
                              $realtime, exp_res.read_value, res.read_value,
                              exp_res.inserted, res.inserted, exp_res.rank, res.rank,
                              exp_res.status, res.status);
               end
            end
         end
      end
      pending = expected_rsp_q.size();
   end

endmodule

FILE: bench/tb_reward_weighted_policy_update.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_reward_weighted_policy_update
// Fills every weight and best trial, runs a directed set of corner cases and
// then random phases of trials under random register settings, with random
// gaps on both channels; the checker beside the block scores every response.
// ----------------------------------------------------------------------------
module tb_reward_weighted_policy_update;
   import rwpu_pkg::*;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_write_en = 1'b0;
   logic [CSR_AW-1:0] csr_index = '0;
   logic [CSR_DW-1:0] csr_data = '0;
   int                pending;
   int                fail_count;
   int                rsp_seen = 0;
   int                items_sent = 0;
   int                cur_len = 64;
   logic [DATA_W-1:0] last_reward = '0;

   rwpu_req_if req_chan ();
   rwpu_rsp_if rsp_chan ();

   reward_weighted_policy_update u_top (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   rwpu_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_chan),
      .rsp_mon      (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .pending      (pending),
      .fail_count   (fail_count)
   );

   always #5 clock = ~clock;

   initial begin
      req_chan.valid  = 1'b0;
      req_chan.opcode = OP_LOAD;
      req_chan.index  = '0;
      req_chan.value  = '0;
      rsp_chan.ready  = 1'b0;
   end

   // Mostly short gaps, a few long ones
   function automatic int gap_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   function automatic logic [DATA_W-1:0] weight_value();
      case ($urandom_range(0, 9))
         0:       return MAX_WORD;
         1:       return MIN_REWARD;
         2:       return '0;
         3:       return $urandom_range(0, 65535) - 32768;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] reward_value();
      case ($urandom_range(0, 9))
         0:       return last_reward;
         1:       return ($urandom_range(0, 1) == 1) ? MAX_WORD : MIN_REWARD;
         2, 3:    return $urandom_range(0, 1 << 20) - (1 << 18);
         default: return $urandom();
      endcase
   endfunction

   // Offer one command and hold it until the transfer; valid stays high
   task automatic send(input opcode_type op, input int idx, input logic [DATA_W-1:0] val);
      if ($urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap_length()) @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.opcode <= op;
      req_chan.index  <= WIDX_W'(idx);
      req_chan.value  <= val;
      if (op == OP_REWARD) last_reward = val;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
   endtask

   // Drop valid and wait until every response has come back
   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   // Write both registers back to back, block idle
   task automatic write_config(input int best, input int len);
      drain();
      csr_write_en <= 1'b1;
      csr_index    <= CSR_BEST_COUNT;
      csr_data     <= CSR_DW'(best);
      @(posedge clock);
      csr_index    <= CSR_VECTOR_LENGTH;
      csr_data     <= CSR_DW'(len);
      @(posedge clock);
      csr_write_en <= 1'b0;
      cur_len = (len < 1) ? 1 : (len > MAX_WEIGHTS) ? MAX_WEIGHTS : len;
   endtask

   // Response side: random stalls, one long hold-off while commands keep coming
   initial begin
      int  gap;
      bit  held;
      gap  = 0;
      held = 0;
      forever begin
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) rsp_seen++;
         if (!held && rsp_seen >= 400 && req_chan.valid) begin
            held = 1;
            gap  = 500;
         end
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (gap > 0) begin
            gap--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) gap = gap_length();
         end
      end
   end

   initial begin
      #50ms;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      int trials, len, best;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Write every policy and trial weight
      for (int i = 0; i < MAX_WEIGHTS; i++) begin
         send(OP_LOAD, i, weight_value());
         send(OP_TRIAL, i, weight_value());
      end
      // Fill each rank in turn with falling rewards so no shift reads empty sets
      for (int r = 0; r < MAX_BEST; r++) begin
         write_config(r + 1, 64);
         send(OP_TRIAL, $urandom_range(0, 63), weight_value());
         send(OP_REWARD, 0, DATA_W'(1 - r));
      end

      // Directed: reward sum negative, lowest reward, equal reward, extremes, range
      send(OP_REWARD, 0, MIN_REWARD);
      send(OP_REWARD, 0, 32'd1);
      send(OP_LOAD, 5, MAX_WORD);
      send(OP_LOAD, 6, MIN_REWARD);
      send(OP_READ, 5, '0);
      send(OP_READ, 6, '0);
      send(OP_READ, 63, '0);
      send(OP_READ, 0, '0);
      write_config(1, 1);
      send(OP_READ, 1, '0);
      send(OP_LOAD, 63, MAX_WORD);
      send(OP_TRIAL, 40, '1);
      send(OP_READ, 0, '0);
      send(OP_REWARD, 0, MAX_WORD);
      write_config(15, 127);
      send(OP_REWARD, 0, 32'd2);
      send(OP_READ, 3, '0);
      write_config(0, 0);
      send(OP_REWARD, 0, 32'd3);
      send(OP_READ, 0, '0);

      // Random phases: mostly well-formed trials, some noise
      while (items_sent < 1200) begin
         best = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
         case ($urandom_range(0, 19))
            0:          len = 64;
            1:          len = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(65, 127);
            2, 3, 4, 5: len = $urandom_range(9, 32);
            default:    len = $urandom_range(1, 8);
         endcase
         write_config(best, len);
         trials = $urandom_range(2, 6);
         for (int t = 0; t < trials; t++) begin
            repeat ($urandom_range(0, cur_len)) begin
               case ($urandom_range(0, 9))
                  0:       send(OP_LOAD, $urandom_range(0, cur_len - 1), weight_value());
                  1:       send(OP_READ, $urandom_range(0, cur_len - 1), '0);
                  2:       send(opcode_type'($urandom_range(0, 3)), $urandom_range(0, 63),
                                weight_value());
                  default: send(OP_TRIAL, $urandom_range(0, cur_len - 1), weight_value());
               endcase
            end
            send(OP_REWARD, $urandom_range(0, 63), reward_value());
            send(OP_READ, $urandom_range(0, cur_len - 1), '0);
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

FILE: sim.f
rtl/rwpu_pkg.sv
rtl/rwpu_req_if.sv
rtl/rwpu_rsp_if.sv
rtl/rwpu_divider.sv
rtl/rwpu_rank.sv
rtl/reward_weighted_policy_update.sv
bench/rwpu_checker.sv
bench/tb_reward_weighted_policy_update.sv
